// ===== rtl/core/rfp_pkg.sv =====
// Shared types, constants and CRC helper for the frame parser.
`default_nettype none
package rfp_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // Commands passed from the front to the back.
  typedef enum logic [1:0] {
    OP_LEN   = 2'd0,  // length byte, restart CRC
    OP_DATA  = 2'd1,  // payload byte
    OP_END   = 2'd2,  // last CRC byte, check and report
    OP_SHORT = 2'd3   // byte after a length below two
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] len;
    logic [7:0] lo;
  } cmd_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rfp_front.sv =====
// Front end: start-symbol hunt, length capture and byte classification.
`default_nettype none
module rfp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          in_tvalid,
  input  wire logic [7:0]    in_tdata,
  input  wire logic          q_full,
  output logic               in_tready,
  output logic               q_push,
  output rfp_pkg::cmd_t      q_cmd
);
  import rfp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] start_r;
  logic [7:0] len_r, len_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic       acc;
  logic [8:0] pos2;
  logic [8:0] len9;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign pos2      = {1'b0, seen_r} + 9'd2;
  assign len9      = {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 8'h00;
    end else if (cfg_valid) begin
      start_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= 8'h00;
      seen_r  <= 8'h00;
      lo_r    <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      lo_r    <= lo_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    lo_nxt      = lo_r;
    q_push      = 1'b0;
    q_cmd.op    = OP_DATA;
    q_cmd.data  = in_tdata;
    q_cmd.idx   = seen_r;
    q_cmd.len   = len_r;
    q_cmd.lo    = lo_r;
    if (acc) begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt   = in_tdata;
          seen_nxt  = 8'h00;
          q_push    = 1'b1;
          q_cmd.op  = OP_LEN;
          q_cmd.len = in_tdata;
          phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          if (len_r < 8'd2) begin
            q_push    = 1'b1;
            q_cmd.op  = OP_SHORT;
            phase_nxt = PH_HUNT;
            len_nxt   = 8'h00;
            seen_nxt  = 8'h00;
            lo_nxt    = 8'h00;
          end else if (pos2 < len9) begin
            q_push   = 1'b1;
            q_cmd.op = OP_DATA;
            seen_nxt = seen_r + 8'd1;
          end else if (pos2 == len9) begin
            lo_nxt   = in_tdata;
            seen_nxt = seen_r + 8'd1;
          end else begin
            q_push    = 1'b1;
            q_cmd.op  = OP_END;
            phase_nxt = PH_HUNT;
            len_nxt   = 8'h00;
            seen_nxt  = 8'h00;
            lo_nxt    = 8'h00;
          end
        end
        default: begin
          // hunting; an unused phase code hunts as well
          phase_nxt = (in_tdata == start_r) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfp_cmd_fifo.sv =====
// Short command queue between the front and the back.
`default_nettype none
module rfp_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rfp_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output rfp_pkg::cmd_t      head_cmd
);
  import rfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("command queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("command queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/core/rfp_back.sv =====
// Back end: running CRC, frame check and output register.
`default_nettype none
module rfp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire rfp_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [55:0]        out_tdata,
  output logic [1:0]         out_tuser
);
  import rfp_pkg::*;

  logic        out_valid_r;
  kind_t       kind_r;
  logic [7:0]  data_r, idx_r, len_r;
  logic [15:0] ccrc_r, rcrc_r;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_end;
  logic [15:0] crc_upd;

  assign q_pop      = !q_empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {rcrc_r, ccrc_r, len_r, idx_r, data_r};
  assign rcrc_end   = {q_cmd.data, q_cmd.lo};
  assign crc_upd    = crc_byte((q_cmd.op == OP_LEN) ? CRC_INIT : crc_r, q_cmd.data);

  always_comb begin
    crc_nxt = crc_r;
    if (q_pop) begin
      unique case (q_cmd.op) inside
        OP_LEN, OP_DATA: crc_nxt = crc_upd;
        OP_END, OP_SHORT: crc_nxt = CRC_INIT;
        default: crc_nxt = crc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_DATA;
    end else begin
      crc_r <= crc_nxt;
      if (q_pop) begin
        out_valid_r <= (q_cmd.op != OP_LEN);
        unique case (q_cmd.op)
          OP_END:   kind_r <= (crc_r == rcrc_end) ? KIND_GOOD : KIND_BAD;
          OP_SHORT: kind_r <= KIND_BAD;
          default:  kind_r <= KIND_DATA;
        endcase
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (q_pop) begin
      len_r <= q_cmd.len;
      unique case (q_cmd.op)
        OP_DATA: begin
          data_r <= q_cmd.data;
          idx_r  <= q_cmd.idx;
          ccrc_r <= 16'h0000;
          rcrc_r <= 16'h0000;
        end
        OP_END: begin
          data_r <= 8'h00;
          idx_r  <= 8'h00;
          ccrc_r <= crc_r;
          rcrc_r <= rcrc_end;
        end
        OP_SHORT: begin
          data_r <= 8'h00;
          idx_r  <= 8'h00;
          ccrc_r <= CRC_INIT;
          rcrc_r <= {q_cmd.data, q_cmd.len};
        end
        default: begin
          data_r <= data_r;
          idx_r  <= idx_r;
          ccrc_r <= ccrc_r;
          rcrc_r <= rcrc_r;
        end
      endcase
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (kind_r == KIND_DATA || kind_r == KIND_GOOD || kind_r == KIND_BAD))
    else $error("illegal result kind");
  a_data_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_DATA) |-> (ccrc_r == 16'h0000 && rcrc_r == 16'h0000))
    else $error("payload result carries CRC fields");
  a_good_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_GOOD) |-> (ccrc_r == rcrc_r))
    else $error("good frame with CRC mismatch");

endmodule
`default_nettype wire

// ===== rtl/core/rx_frame_parser_crc16.sv =====
// Top level of the length-prefixed frame parser with CRC-16 check.
// Receives one byte per transaction, hunts for the configured start symbol,
// takes the next byte as length L (bytes that follow, last two being the CRC,
// low byte first), streams payload bytes out with their index and ends each
// frame with a good/bad CRC report (reflected CRC-16, poly 0x8408, init
// 0xFFFF, no final xor, over length byte and payload). A length below two
// ends the frame on the next byte with a CRC error. Rate: one byte per clock
// sustained while the command queue is not full; out_tvalid rises once the
// input transaction has passed the queue entry and then the output register,
// when the output is free. The front end classifies bytes, a small command queue
// (CMD_DEPTH entries) decouples it from the back end, which runs the CRC and holds
// the output register; in_tready drops only while that queue is full. The user must
// write the start symbol through cfg_* while the parser is idle (not enforced).
`default_nettype none
module rx_frame_parser_crc16 #(
  parameter int CMD_DEPTH = 4   // command queue depth, 2..16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: start_symbol
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,   // [7:0] data_byte, [15:8] payload_index,
                                        // [23:16] frame_length, [39:24] computed_crc,
                                        // [55:40] received_crc
  output logic [1:0]       out_tuser    // [1:0] kind
);
  import rfp_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  // register always writable
  assign cfg_ready = 1'b1;

  rfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .in_tready (in_tready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rfp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  rfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== verif/rx_frame_parser_crc16_tb.sv =====
// Testbench for the CRC-16 frame parser: directed and random byte traffic against a predictor.
`timescale 1ns / 1ps

module rx_frame_parser_crc16_tb;
  import rfp_pkg::*;

  // Cycles to wait after the last report before touching the start symbol:
  // the command queue and the output register, with margin.
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  idx;
    logic [7:0]  len;
    logic [15:0] ccrc;
    logic [15:0] rcrc;
  } parse_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tready = 1'b0;
  wire         cfg_ready;
  wire         in_tready;
  wire         out_tvalid;
  wire  [55:0] out_tdata;
  wire  [1:0]  out_tuser;

  // Parser state as the predictor sees it
  phase_t      parse_phase;
  logic [7:0]  start_sym;
  logic [7:0]  frame_len;
  logic [7:0]  body_count;
  logic [15:0] run_crc;
  logic [7:0]  crc_lo;

  parse_report_t pending_reports[$];
  logic [7:0]    frame_body[$];   // payload for the next send_frame, random where short
  int            err_count = 0;
  int            frame_items = 0; // bytes that the parser does not just skip
  bit            quiet = 1'b0;    // no idling on either side while set
  int            out_stall = 0;

  rx_frame_parser_crc16 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reflected CRC-16, one data bit per shift, LSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int idle_length();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task report_mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("[%0t] mismatch on %s: want %h got %h", $time, what, want, got);
    err_count++;
  endtask

  task restart_hunt;
    parse_phase = PH_HUNT;
    frame_len   = 8'h00;
    body_count  = 8'h00;
    run_crc     = CRC_INIT;
    crc_lo      = 8'h00;
  endtask

  // Byte-level parser model; queues the report that the byte causes, if any.
  task track_parser(input logic [7:0] b);
    parse_report_t r;
    logic [15:0]   rcv;
    r = '0;
    case (parse_phase)
      PH_LEN: begin
        frame_len   = b;
        body_count  = 8'h00;
        run_crc     = crc16_step(CRC_INIT, b);
        parse_phase = PH_BODY;
      end
      PH_BODY: begin
        r.len = frame_len;
        if (frame_len < 8'd2) begin
          // short length: next byte closes the frame as bad
          r.kind = KIND_BAD;
          r.ccrc = CRC_INIT;
          r.rcrc = {b, frame_len};
          pending_reports.push_back(r);
          restart_hunt();
        end else if (int'(body_count) + 2 < int'(frame_len)) begin
          run_crc = crc16_step(run_crc, b);
          r.kind  = KIND_DATA;
          r.data  = b;
          r.idx   = body_count;
          body_count++;
          pending_reports.push_back(r);
        end else if (int'(body_count) + 2 == int'(frame_len)) begin
          crc_lo = b;
          body_count++;
        end else begin
          rcv    = {b, crc_lo};
          r.ccrc = run_crc;
          r.rcrc = rcv;
          if (run_crc == rcv) begin
            r.kind = KIND_GOOD;
          end else begin
            r.kind = KIND_BAD;
          end
          pending_reports.push_back(r);
          restart_hunt();
        end
      end
      default: begin
        if (b == start_sym) begin
          parse_phase = PH_LEN;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  // One input transaction. in_tvalid is left high on return so a following
  // byte can go out back to back; anything that waits must lower it first.
  task send_byte(input logic [7:0] b);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (parse_phase != PH_HUNT || b == start_sym) frame_items++;
    track_parser(b);
  endtask

  // Start symbol, length, body from frame_body (random past its end), CRC; below length two, one closing byte.
  task send_frame(input logic [7:0] len, input bit corrupt);
    logic [15:0] c;
    logic [7:0]  b;
    send_byte(start_sym);
    send_byte(len);
    if (len < 8'd2) begin
      b = (frame_body.size() != 0) ? frame_body[0] : 8'($urandom_range(0, 255));
      send_byte(b);
    end else begin
      c = crc16_step(CRC_INIT, len);
      for (int i = 0; i < int'(len) - 2; i++) begin
        b = (i < frame_body.size()) ? frame_body[i] : 8'($urandom_range(0, 255));
        c = crc16_step(c, b);
        send_byte(b);
      end
      if (corrupt) c = c ^ (16'd1 << $urandom_range(0, 15));
      send_byte(c[7:0]);
      send_byte(c[15:8]);
    end
  endtask

  // Input idle, all reports in, pipeline settled.
  task wait_drained;
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_symbol(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    start_sym = v;
    cfg_valid <= 1'b0;
  endtask

  task test_directed;
    logic [15:0] c;
    // reset symbol 0x00, shortest legal frame: no payload
    frame_body.delete();
    send_frame(8'd2, 1'b0);
    // lengths 0 and 1 close on the next byte
    frame_body.delete();
    frame_body.push_back(8'hFF);
    send_frame(8'd0, 1'b0);
    frame_body.delete();
    frame_body.push_back(8'hA5);
    send_frame(8'd1, 1'b0);
    write_symbol(8'hFF);
    // payload extremes, the second one equal to the start symbol
    frame_body.delete();
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    send_frame(8'd4, 1'b0);
    frame_body.delete();
    frame_body.push_back(8'h80);
    send_frame(8'd3, 1'b1);
    // symbol change with a frame open: takes effect at the next hunt
    send_byte(8'hFF);
    send_byte(8'd2);
    write_symbol(8'h5A);
    c = crc16_step(CRC_INIT, 8'd2);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    send_byte(8'hFF);   // old symbol, skipped now
    frame_body.delete();
    frame_body.push_back(8'h7E);
    send_frame(8'd3, 1'b0);
  endtask

  // Mostly well formed frames, plus noise and frames cut short.
  task test_random_traffic(input int n_items);
    int   base;
    int   pick;
    int   r;
    logic [7:0] len;
    base = frame_items;
    while (frame_items - base < n_items) begin
      pick = $urandom_range(0, 99);
      frame_body.delete();
      if (pick < 70) begin
        r = $urandom_range(0, 99);
        if (r < 8) len = 8'($urandom_range(0, 1));
        else if (r < 88) len = 8'($urandom_range(2, 12));
        else len = 8'($urandom_range(13, 60));
        send_frame(len, $urandom_range(0, 3) == 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // header then too few bytes; whatever follows lands in this frame
        send_byte(start_sym);
        send_byte(8'($urandom_range(2, 12)));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task test_long_frames;
    frame_body.delete();
    send_frame(8'd255, 1'b0);
    send_frame(8'd254, 1'b1);
  endtask

  task test_back_to_back;
    quiet = 1'b1;
    test_random_traffic(180);
    quiet = 1'b0;
  endtask

  // Result side: random back-pressure, every accepted transaction checked
  // against the oldest pending report.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing pending", 16'h0000, {14'd0, out_tuser});
      end else begin
        parse_report_t w;
        w = pending_reports.pop_front();
        if (out_tuser !== w.kind) report_mismatch("kind", {14'd0, w.kind}, {14'd0, out_tuser});
        if (out_tdata[7:0] !== w.data) begin
          report_mismatch("data_byte", {8'd0, w.data}, {8'd0, out_tdata[7:0]});
        end
        if (out_tdata[15:8] !== w.idx) begin
          report_mismatch("payload_index", {8'd0, w.idx}, {8'd0, out_tdata[15:8]});
        end
        if (out_tdata[23:16] !== w.len) begin
          report_mismatch("frame_length", {8'd0, w.len}, {8'd0, out_tdata[23:16]});
        end
        if (out_tdata[39:24] !== w.ccrc) report_mismatch("computed_crc", w.ccrc, out_tdata[39:24]);
        if (out_tdata[55:40] !== w.rcrc) report_mismatch("received_crc", w.rcrc, out_tdata[55:40]);
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall = idle_length();
    end
  end

  initial begin
    start_sym = 8'h00;
    restart_hunt();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    test_directed();
    write_symbol(8'h00);
    test_random_traffic(280);
    write_symbol(8'hFF);
    test_random_traffic(280);
    test_long_frames();
    write_symbol(8'($urandom_range(0, 255)));
    test_random_traffic(280);
    write_symbol(8'($urandom_range(0, 255)));
    test_back_to_back();
    test_random_traffic(180);

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      report_mismatch("results never delivered", 16'h0000, 16'(pending_reports.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
